/* design/fixed_point_sigmoid_silu_unit_macros.svh */
// Assertion macros used by the checker file of the sigmoid / SiLU unit.
`ifndef FIXED_POINT_SIGMOID_SILU_UNIT_MACROS_SVH
`define FIXED_POINT_SIGMOID_SILU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FSSU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked a fixed number of cycles later.
`define FSSU_ASSERT_LAT(lbl, clk, rst, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

/* design/fssu_pkg.sv */
// Shared constants, types and helper functions of the sigmoid / SiLU unit.
package fssu_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int SCALE      = 4096;
  localparam int TAIL_INDEX = 8;
  localparam int LATENCY    = 11;
  localparam logic signed [31:0] SAT_LIMIT = 32'sd36864;

  localparam logic [1:0] FUNC_SIGMOID = 2'd0;
  localparam logic [1:0] FUNC_SILU    = 2'd1;
  localparam logic [1:0] FUNC_SWIGLU  = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  // Operand description carried alongside the divider.
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic               sat_hi1;
    logic               sat_lo1;
    logic               neg1;
    logic               sat_hi2;
    logic               sat_lo2;
    logic               neg2;
    logic signed [31:0] opb;
  } side_t;

  // exp(-k) in Q12 for k = 0..9.
  function automatic logic [12:0] exp_rom(input logic [3:0] idx);
    case (idx)
      4'd0:    return 13'd4096;
      4'd1:    return 13'd1507;
      4'd2:    return 13'd554;
      4'd3:    return 13'd204;
      4'd4:    return 13'd75;
      4'd5:    return 13'd28;
      4'd6:    return 13'd10;
      4'd7:    return 13'd4;
      4'd8:    return 13'd1;
      default: return 13'd0;
    endcase
  endfunction

  // Quotient by the scale, truncated toward zero.
  function automatic logic signed [19:0] div_scale(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v >>> FRAC_BITS;
    if (v[31] && (v[11:0] != 12'd0)) begin
      t = t + 32'sd1;
    end
    return t[19:0];
  endfunction

  // Remainder by the scale, carrying the sign of the dividend.
  function automatic logic signed [12:0] mod_scale(input logic signed [31:0] v);
    logic signed [12:0] r;
    r = $signed({1'b0, v[11:0]});
    if (v[31] && (v[11:0] != 12'd0)) begin
      r = r - 13'sd4096;
    end
    return r;
  endfunction

endpackage

/* design/fssu_exp.sv */
// Front end: operand scaling, magnitude, table lookup and interpolation of exp(-|x|).
module fssu_exp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [1:0]           func_i,
  input  logic signed [31:0]   opa_i,
  input  logic signed [31:0]   opb_i,
  output logic                 vld_o,
  output fssu_pkg::side_t      side_o,
  output logic [13:0]          den_o,
  output logic [25:0]          rem_o
);

  logic                 vld_a_q, vld_b_q, vld_c_q;
  fssu_pkg::side_t      side_a_d, side_a_q, side_b_q, side_c_q;
  logic [15:0]          m_a_d, m_a_q;
  logic [12:0]          lo_b_d, lo_b_q;
  logic [24:0]          prod_b_d, prod_b_q;
  logic                 zero_b_q, tail_b_q;
  logic [13:0]          den_c_d, den_c_q;
  logic [25:0]          num_c_d, num_c_q;
  logic [31:0]          mag;
  logic [3:0]           k;
  logic [12:0]          hi, diff, e;

  always_comb begin
    side_a_d.func = func_i;
    side_a_d.opb  = opb_i;
    side_a_d.x1   = (func_i == fssu_pkg::FUNC_SWIGLU) ? {opa_i[19:0], 12'd0} : opa_i;
    side_a_d.x2   = 32'sd0 - side_a_d.x1;
    side_a_d.sat_hi1 = side_a_d.x1 >= fssu_pkg::SAT_LIMIT;
    side_a_d.sat_lo1 = side_a_d.x1 <= -fssu_pkg::SAT_LIMIT;
    side_a_d.neg1    = side_a_d.x1[31];
    side_a_d.sat_hi2 = side_a_d.x2 >= fssu_pkg::SAT_LIMIT;
    side_a_d.sat_lo2 = side_a_d.x2 <= -fssu_pkg::SAT_LIMIT;
    side_a_d.neg2    = side_a_d.x2[31];
    mag   = side_a_d.x1[31] ? (32'd0 - side_a_d.x1) : side_a_d.x1;
    m_a_d = mag[15:0];
  end

  assign k        = m_a_q[15:12];
  assign lo_b_d   = fssu_pkg::exp_rom(k);
  assign hi       = fssu_pkg::exp_rom(k + 4'd1);
  assign diff     = lo_b_d - hi;
  assign prod_b_d = 25'(diff * m_a_q[11:0]);

  always_comb begin
    if (zero_b_q) begin
      e = 13'(fssu_pkg::SCALE);
    end else if (tail_b_q) begin
      e = 13'd0;
    end else begin
      e = lo_b_q - prod_b_q[24:12];
    end
    den_c_d = 14'(fssu_pkg::SCALE) + 14'(e);
    num_c_d = 26'd16777216 + 26'(den_c_d >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_a_q <= side_a_d;
    m_a_q    <= m_a_d;
    side_b_q <= side_a_q;
    lo_b_q   <= lo_b_d;
    prod_b_q <= prod_b_d;
    zero_b_q <= (m_a_q == 16'd0);
    tail_b_q <= (32'(k) >= fssu_pkg::TAIL_INDEX);
    side_c_q <= side_b_q;
    den_c_q  <= den_c_d;
    num_c_q  <= num_c_d;
  end

  assign vld_o  = vld_c_q;
  assign side_o = side_c_q;
  assign den_o  = den_c_q;
  assign rem_o  = num_c_q;

endmodule

/* design/fssu_div_stage.sv */
// One registered slice of the restoring divider for the sigmoid quotient.
module fssu_div_stage #(
  parameter int TOP_BIT  = 12,
  parameter int NUM_BITS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  fssu_pkg::side_t  side_i,
  input  logic [13:0]      den_i,
  input  logic [25:0]      rem_i,
  input  logic [12:0]      quo_i,
  output logic             vld_o,
  output fssu_pkg::side_t  side_o,
  output logic [13:0]      den_o,
  output logic [25:0]      rem_o,
  output logic [12:0]      quo_o
);

  logic             vld_q;
  fssu_pkg::side_t  side_q;
  logic [13:0]      den_q;
  logic [25:0]      rem_d, rem_q;
  logic [12:0]      quo_d, quo_q;

  always_comb begin
    logic [26:0] trial;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int i = 0; i < NUM_BITS; i++) begin
      trial = 27'(den_i) << (TOP_BIT - i);
      if ({1'b0, rem_d} >= trial) begin
        rem_d = 26'({1'b0, rem_d} - trial);
        quo_d = quo_d | (13'd1 << (TOP_BIT - i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    den_q  <= den_i;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

/* design/fssu_silu.sv */
// Back end: sigmoid selection, SiLU split products and the SwiGLU product sum.
module fssu_silu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  fssu_pkg::side_t     side_i,
  input  logic [13:0]         den_i,
  input  logic [25:0]         rem_i,
  input  logic [12:0]         quo_i,
  output logic                done_o,
  output logic signed [31:0]  result_o
);

  // Stage G: both sigmoid values.
  logic               vld_g_q;
  fssu_pkg::side_t    side_g_q;
  logic [12:0]        s1_d, s1_q, s2_d, s2_q, sneg;
  logic [14:0]        twoh, rsum;
  logic [13:0]        base;

  always_comb begin
    twoh = {1'b0, den_i[13:1], 1'b0};
    rsum = 15'(rem_i[13:0]) + 15'(den_i);
    base = 14'(fssu_pkg::SCALE) - 14'(quo_i);
    if (twoh >= rsum) begin
      base = base + 14'd1;
    end else if (twoh < 15'(rem_i[13:0])) begin
      base = base - 14'd1;
    end
    sneg = base[12:0];
    if (side_i.sat_hi1)      s1_d = 13'(fssu_pkg::SCALE);
    else if (side_i.sat_lo1) s1_d = 13'd0;
    else if (side_i.neg1)    s1_d = sneg;
    else                     s1_d = quo_i;
    if (side_i.sat_hi2)      s2_d = 13'(fssu_pkg::SCALE);
    else if (side_i.sat_lo2) s2_d = 13'd0;
    else if (side_i.neg2)    s2_d = sneg;
    else                     s2_d = quo_i;
  end

  // Stage M1: split products of x by its sigmoid.
  logic               vld_m1_q;
  logic [1:0]         func_m1_q;
  logic signed [31:0] opb_m1_q;
  logic [12:0]        s1_m1_q;
  logic signed [31:0] hi1_d, hi1_q, hi2_d, hi2_q;
  logic signed [24:0] lp1_d, lp1_q, lp2_d, lp2_q;

  always_comb begin
    hi1_d = 32'(fssu_pkg::div_scale(side_g_q.x1)) * 32'($signed({1'b0, s1_q}));
    hi2_d = 32'(fssu_pkg::div_scale(side_g_q.x2)) * 32'($signed({1'b0, s2_q}));
    lp1_d = 25'(fssu_pkg::mod_scale(side_g_q.x1)) * 25'($signed({1'b0, s1_q}));
    lp2_d = 25'(fssu_pkg::mod_scale(side_g_q.x2)) * 25'($signed({1'b0, s2_q}));
  end

  // Stage M2: rounded SiLU values.
  logic               vld_m2_q;
  logic [1:0]         func_m2_q;
  logic signed [31:0] opb_m2_q;
  logic signed [31:0] sp_d, sp_q, sn_d, sn_q, pre_d, pre_q;

  always_comb begin
    sp_d = hi1_q + 32'(fssu_pkg::div_scale(32'(lp1_q) + 32'sd2048));
    sn_d = hi2_q + 32'(fssu_pkg::div_scale(32'(lp2_q) + 32'sd2048));
    case (func_m1_q)
      fssu_pkg::FUNC_SIGMOID: pre_d = $signed({19'd0, s1_m1_q});
      fssu_pkg::FUNC_SILU:    pre_d = sp_d;
      default:                pre_d = 32'sd0;
    endcase
  end

  // Stage M3: the four partial products of the SwiGLU sum.
  logic               vld_m3_q;
  logic [1:0]         func_m3_q;
  logic signed [31:0] pre_m3_q;
  logic signed [31:0] nb;
  logic signed [31:0] p1_d, p1_q, p2_d, p2_q, p3_d, p3_q, p4_d, p4_q;

  always_comb begin
    nb   = 32'sd0 - opb_m2_q;
    p1_d = 32'(fssu_pkg::div_scale(sp_q)) * opb_m2_q;
    p2_d = 32'(fssu_pkg::div_scale(sn_q)) * nb;
    p3_d = 32'(fssu_pkg::mod_scale(sp_q)) * opb_m2_q;
    p4_d = 32'(fssu_pkg::mod_scale(sn_q)) * nb;
  end

  // Stage M4: final sums and the output register.
  logic               done_q;
  logic signed [31:0] res_d, res_q, ip, fs;

  always_comb begin
    ip = p1_q + p2_q;
    fs = p3_q + p4_q + 32'sd2048;
    if (func_m3_q == fssu_pkg::FUNC_SWIGLU) begin
      res_d = ip + 32'(fssu_pkg::div_scale(fs));
    end else begin
      res_d = pre_m3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_g_q  <= 1'b0;
      vld_m1_q <= 1'b0;
      vld_m2_q <= 1'b0;
      vld_m3_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      vld_g_q  <= vld_i;
      vld_m1_q <= vld_g_q;
      vld_m2_q <= vld_m1_q;
      vld_m3_q <= vld_m2_q;
      done_q   <= vld_m3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_g_q  <= side_i;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    func_m1_q <= side_g_q.func;
    opb_m1_q  <= side_g_q.opb;
    s1_m1_q   <= s1_q;
    hi1_q     <= hi1_d;
    hi2_q     <= hi2_d;
    lp1_q     <= lp1_d;
    lp2_q     <= lp2_d;
    func_m2_q <= func_m1_q;
    opb_m2_q  <= opb_m1_q;
    sp_q      <= sp_d;
    sn_q      <= sn_d;
    pre_q     <= pre_d;
    func_m3_q <= func_m2_q;
    pre_m3_q  <= pre_q;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    p3_q      <= p3_d;
    p4_q      <= p4_d;
    res_q     <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* design/fixed_point_sigmoid_silu_unit.sv */
// Top level of the Q12 sigmoid / SiLU / SwiGLU-product pipeline.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+-----------------------------------
//   request  | start high, busy low   | func_i, operand_a_i, operand_b_i
//   result   | done_o, one cycle      | result_o
//
// A new request may be accepted in every cycle. The pipeline is made of the
// three-stage front end (scaling, table lookup, interpolation), the
// three-slice restoring divider for the sigmoid quotient and the five-stage
// back end of multipliers and adders. Reset clears only the valid bits, so
// no result appears until a request has travelled the full pipeline. The
// receiver cannot hold results off, so the pipeline never stalls and busy
// stays low.
module fixed_point_sigmoid_silu_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output logic                done_o,
  output logic signed [31:0]  result_o
);

  // The pipeline always moves, so a request is never refused.
  assign busy = 1'b0;

  logic             vld_e, vld_d0, vld_d1, vld_d2;
  fssu_pkg::side_t  side_e, side_d0, side_d1, side_d2;
  logic [13:0]      den_e, den_d0, den_d1, den_d2;
  logic [25:0]      rem_e, rem_d0, rem_d1, rem_d2;
  logic [12:0]      quo_d0, quo_d1, quo_d2;

  // Scales the operand, takes its magnitude and interpolates exp(-|x|).
  fssu_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start && !busy),
    .func_i (func_i),
    .opa_i  (operand_a_i),
    .opb_i  (operand_b_i),
    .vld_o  (vld_e),
    .side_o (side_e),
    .den_o  (den_e),
    .rem_o  (rem_e)
  );

  // The sigmoid quotient has thirteen bits; they are resolved five, four and
  // four at a time. The remainder is kept, since the sigmoid of the negated
  // argument follows from the same quotient and remainder.
  fssu_div_stage #(.TOP_BIT(12), .NUM_BITS(5)) u_div0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_e),
    .side_i (side_e),
    .den_i  (den_e),
    .rem_i  (rem_e),
    .quo_i  (13'd0),
    .vld_o  (vld_d0),
    .side_o (side_d0),
    .den_o  (den_d0),
    .rem_o  (rem_d0),
    .quo_o  (quo_d0)
  );

  fssu_div_stage #(.TOP_BIT(7), .NUM_BITS(4)) u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_d0),
    .side_i (side_d0),
    .den_i  (den_d0),
    .rem_i  (rem_d0),
    .quo_i  (quo_d0),
    .vld_o  (vld_d1),
    .side_o (side_d1),
    .den_o  (den_d1),
    .rem_o  (rem_d1),
    .quo_o  (quo_d1)
  );

  fssu_div_stage #(.TOP_BIT(3), .NUM_BITS(4)) u_div2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_d1),
    .side_i (side_d1),
    .den_i  (den_d1),
    .rem_i  (rem_d1),
    .quo_i  (quo_d1),
    .vld_o  (vld_d2),
    .side_o (side_d2),
    .den_o  (den_d2),
    .rem_o  (rem_d2),
    .quo_o  (quo_d2)
  );

  // Selects the sigmoid values and forms SiLU and the SwiGLU product.
  fssu_silu u_silu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld_d2),
    .side_i   (side_d2),
    .den_i    (den_d2),
    .rem_i    (rem_d2),
    .quo_i    (quo_d2),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

/* design/fssu_checker.sv */
// Port-level checker of the sigmoid / SiLU unit and its bind statement.
`include "fixed_point_sigmoid_silu_unit_macros.svh"

module fssu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [1:0]          func_i,
  input logic                done_o,
  input logic signed [31:0]  result_o
);

  `FSSU_ASSERT_LAT(a_done_follows, clk_i, rst_ni, start && !busy, fssu_pkg::LATENCY,
                   done_o, "request gave no result")
  `FSSU_ASSERT_IMPL(a_done_has_request, clk_i, rst_ni, done_o,
                    $past(start && !busy, fssu_pkg::LATENCY), "result without request")
  `FSSU_ASSERT_LAT(a_sigmoid_range, clk_i, rst_ni,
                   start && !busy && func_i == fssu_pkg::FUNC_SIGMOID, fssu_pkg::LATENCY,
                   result_o >= 0 && result_o <= 4096, "sigmoid out of range")
  `FSSU_ASSERT_LAT(a_none_zero, clk_i, rst_ni,
                   start && !busy && func_i == fssu_pkg::FUNC_NONE, fssu_pkg::LATENCY,
                   result_o == 0, "unused selector gave non-zero")

endmodule

bind fixed_point_sigmoid_silu_unit fssu_checker u_fssu_checker (.*);
